### rtl/a2i_pkg.sv
// a2i_pkg: shared types, constants and the digit decode function for the
// ascii to integer parser; no dependencies
package a2i_pkg;

   localparam int CHR_BITS       = 8;
   localparam int BASE_BITS      = 6;
   localparam int DIGIT_BITS     = 6;
   localparam int VALUE_BITS     = 64;
   localparam int CONSUMED_BITS  = 16;
   localparam int ERROR_BITS     = 2;
   localparam int RSP_DATA_BITS  = 88;
   localparam int CSR_INDEX_BITS = 1;

   // register indexes on the csr channel
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE   = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIGNED = 1'b1;

   // error codes
   localparam logic [ERROR_BITS-1:0] ERR_OK    = 2'd0;
   localparam logic [ERROR_BITS-1:0] ERR_RANGE = 2'd1;
   localparam logic [ERROR_BITS-1:0] ERR_BASE  = 2'd2;

   // bases
   localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_BITS-1:0] BASE_ONE  = 6'd1;
   localparam logic [BASE_BITS-1:0] BASE_MIN  = 6'd2;
   localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;
   localparam logic [BASE_BITS-1:0] BASE_MAX  = 6'd36;

   // digit code for a byte that is no digit at all, above every base
   localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = 6'd63;

   // characters
   localparam logic [CHR_BITS-1:0] CHR_TAB   = 8'h09;
   localparam logic [CHR_BITS-1:0] CHR_CR    = 8'h0D;
   localparam logic [CHR_BITS-1:0] CHR_SPACE = 8'h20;
   localparam logic [CHR_BITS-1:0] CHR_PLUS  = 8'h2B;
   localparam logic [CHR_BITS-1:0] CHR_MINUS = 8'h2D;
   localparam logic [CHR_BITS-1:0] CHR_0     = 8'h30;
   localparam logic [CHR_BITS-1:0] CHR_9     = 8'h39;
   localparam logic [CHR_BITS-1:0] CHR_UA    = 8'h41;
   localparam logic [CHR_BITS-1:0] CHR_UX    = 8'h58;
   localparam logic [CHR_BITS-1:0] CHR_UZ    = 8'h5A;
   localparam logic [CHR_BITS-1:0] CHR_LA    = 8'h61;
   localparam logic [CHR_BITS-1:0] CHR_LX    = 8'h78;
   localparam logic [CHR_BITS-1:0] CHR_LZ    = 8'h7A;

   // limits
   localparam logic [VALUE_BITS-1:0] SIGNED_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_BITS-1:0] SIGNED_MIN   = 64'h8000_0000_0000_0000;
   localparam logic [VALUE_BITS-1:0] UNSIGNED_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WS,
      PH_SIGNED,
      PH_ZERO,
      PH_ZERO_X,
      PH_DIGITS
   } phase_type;

   // which base a digit is checked against
   typedef enum logic [1:0] {
      BSEL_KEEP,
      BSEL_AUTO10,
      BSEL_AUTO8,
      BSEL_HEX
   } base_sel_type;

   // datapath state update
   typedef enum logic [2:0] {
      OP_NONE,
      OP_ADVANCE,
      OP_SIGN,
      OP_ZERO,
      OP_DIGIT,
      OP_BAD_BASE
   } dp_op_type;

   // result formed for the output register
   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_FINISH,
      EMIT_OVERFLOW,
      EMIT_BAD_BASE,
      EMIT_DANGLING
   } emit_type;

   // selection issued before the character is judged
   typedef struct packed {
      logic         restart;
      base_sel_type base_sel;
   } sel_type;

   // command issued once the character is judged
   typedef struct packed {
      logic      fire;
      logic      load;
      dp_op_type op;
      emit_type  emit;
   } cmd_type;

   // character class and digit checks from the datapath
   typedef struct packed {
      logic is_ws;
      logic is_sign;
      logic is_zero;
      logic is_x;
      logic is_hex;
      logic wb_auto;
      logic cfg_bad;
      logic digit_ok;
      logic overflow;
   } stat_type;

   function automatic logic [DIGIT_BITS-1:0] digit_value(input logic [CHR_BITS-1:0] c);
      logic [DIGIT_BITS-1:0] d;
      d = DIGIT_NONE;
      if (c >= CHR_0 && c <= CHR_9) begin
         d = DIGIT_BITS'(c - CHR_0);
      end else if (c >= CHR_LA && c <= CHR_LZ) begin
         d = DIGIT_BITS'(c - CHR_LA) + BASE_DEC;
      end else if (c >= CHR_UA && c <= CHR_UZ) begin
         d = DIGIT_BITS'(c - CHR_UA) + BASE_DEC;
      end
      return d;
   endfunction

endpackage

### rtl/a2i_ctrl.sv
// a2i_ctrl: conversion phase state machine and stream handshake control
// depends on a2i_pkg
module a2i_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_start,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  a2i_pkg::stat_type stat,
   output a2i_pkg::sel_type  sel,
   output a2i_pkg::cmd_type  cmd
);

   a2i_pkg::phase_type phase_ff, phase_in, eff_phase;
   a2i_pkg::phase_type take_next, first_next;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               fire;
   logic               take_ok;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign fire       = req_tvalid && req_tready;

   // a start character is handled as if the phase were whitespace skip
   assign eff_phase  = req_start ? a2i_pkg::PH_WS : phase_ff;
   assign take_ok    = stat.digit_ok && !stat.overflow;
   assign take_next  = take_ok ? a2i_pkg::PH_DIGITS : a2i_pkg::PH_IDLE;
   assign first_next = (stat.wb_auto && stat.is_zero) ? a2i_pkg::PH_ZERO : take_next;

   // base selection depends on phase only
   always_comb begin
      sel.restart = fire && req_start;
      case (eff_phase)
         a2i_pkg::PH_ZERO:   sel.base_sel = a2i_pkg::BSEL_AUTO8;
         a2i_pkg::PH_ZERO_X: sel.base_sel = a2i_pkg::BSEL_HEX;
         a2i_pkg::PH_DIGITS: sel.base_sel = a2i_pkg::BSEL_KEEP;
         default:            sel.base_sel = a2i_pkg::BSEL_AUTO10;
      endcase
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         if (req_start && stat.cfg_bad) begin
            phase_in = a2i_pkg::PH_IDLE;
         end else begin
            case (eff_phase)
               a2i_pkg::PH_WS: begin
                  if (stat.is_ws) phase_in = a2i_pkg::PH_WS;
                  else if (stat.is_sign) phase_in = a2i_pkg::PH_SIGNED;
                  else phase_in = first_next;
               end
               a2i_pkg::PH_SIGNED: phase_in = first_next;
               a2i_pkg::PH_ZERO: begin
                  phase_in = stat.is_x ? a2i_pkg::PH_ZERO_X : take_next;
               end
               a2i_pkg::PH_ZERO_X: begin
                  phase_in = stat.is_hex ? take_next : a2i_pkg::PH_IDLE;
               end
               a2i_pkg::PH_DIGITS: phase_in = take_next;
               default:            phase_in = a2i_pkg::PH_IDLE;
            endcase
         end
      end
   end

   // outputs
   always_comb begin
      cmd.fire = fire;
      cmd.op   = a2i_pkg::OP_NONE;
      cmd.emit = a2i_pkg::EMIT_NONE;
      if (req_start && stat.cfg_bad) begin
         cmd.op   = a2i_pkg::OP_BAD_BASE;
         cmd.emit = a2i_pkg::EMIT_BAD_BASE;
      end else begin
         case (eff_phase)
            a2i_pkg::PH_WS, a2i_pkg::PH_SIGNED: begin
               if (eff_phase == a2i_pkg::PH_WS && stat.is_ws) begin
                  cmd.op = a2i_pkg::OP_ADVANCE;
               end else if (eff_phase == a2i_pkg::PH_WS && stat.is_sign) begin
                  cmd.op = a2i_pkg::OP_SIGN;
               end else if (stat.wb_auto && stat.is_zero) begin
                  cmd.op = a2i_pkg::OP_ZERO;
               end else if (!stat.digit_ok) begin
                  cmd.emit = a2i_pkg::EMIT_FINISH;
               end else if (stat.overflow) begin
                  cmd.emit = a2i_pkg::EMIT_OVERFLOW;
               end else begin
                  cmd.op = a2i_pkg::OP_DIGIT;
               end
            end
            a2i_pkg::PH_ZERO, a2i_pkg::PH_ZERO_X, a2i_pkg::PH_DIGITS: begin
               if (eff_phase == a2i_pkg::PH_ZERO && stat.is_x) begin
                  cmd.op = a2i_pkg::OP_ADVANCE;
               end else if (eff_phase == a2i_pkg::PH_ZERO_X && !stat.is_hex) begin
                  cmd.emit = a2i_pkg::EMIT_DANGLING;
               end else if (!stat.digit_ok) begin
                  cmd.emit = a2i_pkg::EMIT_FINISH;
               end else if (stat.overflow) begin
                  cmd.emit = a2i_pkg::EMIT_OVERFLOW;
               end else begin
                  cmd.op = a2i_pkg::OP_DIGIT;
               end
            end
            default: begin
               cmd.op   = a2i_pkg::OP_NONE;
               cmd.emit = a2i_pkg::EMIT_NONE;
            end
         endcase
      end
      cmd.load = fire && (cmd.emit != a2i_pkg::EMIT_NONE);
   end

   always_comb begin
      if (cmd.load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= a2i_pkg::PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/a2i_dpath.sv
// a2i_dpath: configuration registers, accumulator with digit multiply-add
// and limit check, position counter and result register; depends on a2i_pkg
module a2i_dpath #(
   parameter int COUNT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [a2i_pkg::CHR_BITS-1:0]          chr,
   input  a2i_pkg::sel_type                      sel,
   input  a2i_pkg::cmd_type                      cmd,
   output a2i_pkg::stat_type                     stat,
   input  logic                                  csr_valid,
   input  logic [a2i_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [a2i_pkg::BASE_BITS-1:0]         csr_wdata,
   output logic [a2i_pkg::VALUE_BITS-1:0]        rsp_value,
   output logic [a2i_pkg::CONSUMED_BITS-1:0]     rsp_consumed,
   output logic [a2i_pkg::ERROR_BITS-1:0]        rsp_error
);

   localparam int SUM_BITS  = a2i_pkg::VALUE_BITS + a2i_pkg::BASE_BITS + 1;
   localparam int WIDE_BITS = (COUNT_BITS > a2i_pkg::CONSUMED_BITS) ?
                              COUNT_BITS : a2i_pkg::CONSUMED_BITS;

   logic [a2i_pkg::BASE_BITS-1:0]     cfg_base_ff;
   logic                              cfg_signed_ff;

   logic [a2i_pkg::VALUE_BITS-1:0]    acc_ff, acc_in, acc_cur;
   logic                              neg_ff, neg_in, neg_cur;
   logic [COUNT_BITS-1:0]             pos_ff, pos_in, pos_cur, pos_adv;
   logic                              started_ff, started_in, started_cur;
   logic [a2i_pkg::BASE_BITS-1:0]     wb_ff, wb_in, wb_cur;

   logic [a2i_pkg::VALUE_BITS-1:0]    value_ff, value_in;
   logic [a2i_pkg::CONSUMED_BITS-1:0] consumed_ff, consumed_in;
   logic [a2i_pkg::ERROR_BITS-1:0]    error_ff, error_in;

   logic [a2i_pkg::DIGIT_BITS-1:0]    digit;
   logic [a2i_pkg::BASE_BITS-1:0]     base_pick, base_eff;
   logic [SUM_BITS-1:0]               sum;
   logic [a2i_pkg::VALUE_BITS-1:0]    limit;
   logic [COUNT_BITS-1:0]             pos_out;
   logic [WIDE_BITS-1:0]              pos_wide;

   // a start character sees cleared state and the configured base
   assign acc_cur     = sel.restart ? '0 : acc_ff;
   assign neg_cur     = sel.restart ? 1'b0 : neg_ff;
   assign pos_cur     = sel.restart ? '0 : pos_ff;
   assign started_cur = sel.restart ? 1'b0 : started_ff;
   assign wb_cur      = sel.restart ? cfg_base_ff : wb_ff;
   assign pos_adv     = (pos_cur == '1) ? pos_cur : pos_cur + 1'b1;

   assign digit = a2i_pkg::digit_value(chr);

   always_comb begin
      case (sel.base_sel)
         a2i_pkg::BSEL_AUTO10: begin
            base_pick = (wb_cur == a2i_pkg::BASE_AUTO) ? a2i_pkg::BASE_DEC : wb_cur;
         end
         a2i_pkg::BSEL_AUTO8: begin
            base_pick = (wb_cur == a2i_pkg::BASE_AUTO) ? a2i_pkg::BASE_OCT : wb_cur;
         end
         a2i_pkg::BSEL_HEX: base_pick = a2i_pkg::BASE_HEX;
         default:           base_pick = wb_cur;
      endcase
      if (base_pick < a2i_pkg::BASE_MIN || base_pick > a2i_pkg::BASE_MAX) begin
         base_eff = a2i_pkg::BASE_DEC;
      end else begin
         base_eff = base_pick;
      end
   end

   // exact overflow test: acc * base + digit above the limit
   always_comb begin
      if (cfg_signed_ff) limit = neg_cur ? a2i_pkg::SIGNED_MIN : a2i_pkg::SIGNED_MAX;
      else limit = a2i_pkg::UNSIGNED_MAX;
   end

   assign sum = SUM_BITS'(acc_cur) * SUM_BITS'(base_eff) + SUM_BITS'(digit);

   always_comb begin
      stat.is_ws    = (chr == a2i_pkg::CHR_SPACE) ||
                      (chr >= a2i_pkg::CHR_TAB && chr <= a2i_pkg::CHR_CR);
      stat.is_sign  = (chr == a2i_pkg::CHR_MINUS) || (chr == a2i_pkg::CHR_PLUS);
      stat.is_zero  = (chr == a2i_pkg::CHR_0);
      stat.is_x     = (chr == a2i_pkg::CHR_LX) || (chr == a2i_pkg::CHR_UX);
      stat.is_hex   = (digit < a2i_pkg::BASE_HEX);
      stat.wb_auto  = (wb_cur == a2i_pkg::BASE_AUTO) || (wb_cur == a2i_pkg::BASE_HEX);
      stat.cfg_bad  = (cfg_base_ff == a2i_pkg::BASE_ONE) ||
                      (cfg_base_ff > a2i_pkg::BASE_MAX);
      stat.digit_ok = (digit < base_eff);
      stat.overflow = (sum > SUM_BITS'(limit));
   end

   // state update
   always_comb begin
      acc_in     = acc_cur;
      neg_in     = neg_cur;
      pos_in     = pos_cur;
      started_in = started_cur;
      wb_in      = wb_cur;
      case (cmd.op)
         a2i_pkg::OP_ADVANCE: pos_in = pos_adv;
         a2i_pkg::OP_SIGN: begin
            neg_in = (chr == a2i_pkg::CHR_MINUS);
            pos_in = pos_adv;
         end
         a2i_pkg::OP_ZERO: begin
            acc_in     = '0;
            started_in = 1'b1;
            pos_in     = pos_adv;
         end
         a2i_pkg::OP_DIGIT: begin
            acc_in     = sum[a2i_pkg::VALUE_BITS-1:0];
            started_in = 1'b1;
            pos_in     = pos_adv;
            wb_in      = base_eff;
         end
         a2i_pkg::OP_BAD_BASE: wb_in = a2i_pkg::BASE_DEC;
         default: acc_in = acc_cur;
      endcase
   end

   // result forming, count saturates to the output width
   always_comb begin
      value_in = '0;
      error_in = a2i_pkg::ERR_OK;
      pos_out  = started_cur ? pos_cur : '0;
      case (cmd.emit)
         a2i_pkg::EMIT_FINISH: begin
            value_in = neg_cur ? ('0 - acc_cur) : acc_cur;
         end
         a2i_pkg::EMIT_OVERFLOW: begin
            error_in = a2i_pkg::ERR_RANGE;
            if (cfg_signed_ff) begin
               value_in = neg_cur ? a2i_pkg::SIGNED_MIN : a2i_pkg::SIGNED_MAX;
            end else begin
               value_in = a2i_pkg::UNSIGNED_MAX;
            end
         end
         a2i_pkg::EMIT_BAD_BASE: begin
            error_in = a2i_pkg::ERR_BASE;
            pos_out  = '0;
         end
         a2i_pkg::EMIT_DANGLING: begin
            pos_out = (pos_cur != '0) ? pos_cur - 1'b1 : '0;
         end
         default: value_in = '0;
      endcase
      pos_wide = WIDE_BITS'(pos_out);
      if (pos_wide > WIDE_BITS'({a2i_pkg::CONSUMED_BITS{1'b1}})) begin
         consumed_in = '1;
      end else begin
         consumed_in = pos_wide[a2i_pkg::CONSUMED_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_base_ff   <= a2i_pkg::BASE_DEC;
         cfg_signed_ff <= 1'b1;
         acc_ff        <= '0;
         neg_ff        <= 1'b0;
         pos_ff        <= '0;
         started_ff    <= 1'b0;
         wb_ff         <= a2i_pkg::BASE_DEC;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               a2i_pkg::CSR_BASE:   cfg_base_ff   <= csr_wdata;
               a2i_pkg::CSR_SIGNED: cfg_signed_ff <= csr_wdata[0];
               default:             cfg_base_ff   <= cfg_base_ff;
            endcase
         end
         if (cmd.fire) begin
            acc_ff     <= acc_in;
            neg_ff     <= neg_in;
            pos_ff     <= pos_in;
            started_ff <= started_in;
            wb_ff      <= wb_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff    <= value_in;
         consumed_ff <= consumed_in;
         error_ff    <= error_in;
      end
   end

   assign rsp_value    = value_ff;
   assign rsp_consumed = consumed_ff;
   assign rsp_error    = error_ff;

endmodule

### rtl/ascii_to_integer_parser.sv
// ascii_to_integer_parser: top level of the streaming string to integer
// converter; depends on a2i_pkg, a2i_ctrl and a2i_dpath
//
// usage
//  - req channel: one character per transaction, req_tdata is the byte and
//    req_tuser marks the first character of a new conversion
//  - the block skips whitespace, takes a sign, picks or strips the base
//    prefix and accumulates digits; the first byte that is not taken ends
//    the conversion and one rsp transaction carries value, consumed, error
//  - csr channel: index 0 is the base (0 auto, 2..36), index 1 is signed
//    mode; csr_ready is always high, write only while no conversion is open
//  - throughput: one character per cycle while no result blocks input; each
//    is judged when taken, with one 64 by 6 multiply-add and limit compare
//  - latency: the result is in the output register the cycle after the
//    ending character is accepted
//  - a result waiting in the output register blocks input while rsp_tready
//    is low; when rsp_tready is high input flows on with no gap
//  - reset: synchronous, clears the phase to idle, base to 10, signed mode
//    to 1 and drops any pending result; characters without a start mark
//    while idle are absorbed silently
module ascii_to_integer_parser #(
   parameter int COUNT_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // input characters
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [7:0]                              req_tdata,   // chr
   input  logic                                    req_tuser,   // start_req
   // conversion results
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // value [63:0], consumed [79:64], error [81:80], zero fill [87:82]
   output logic [a2i_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   // register writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [a2i_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [a2i_pkg::BASE_BITS-1:0]           csr_wdata
);

   localparam int FILL_BITS = a2i_pkg::RSP_DATA_BITS - a2i_pkg::VALUE_BITS -
                              a2i_pkg::CONSUMED_BITS - a2i_pkg::ERROR_BITS;

   a2i_pkg::sel_type                   sel;
   a2i_pkg::cmd_type                   cmd;
   a2i_pkg::stat_type                  stat;
   logic [a2i_pkg::VALUE_BITS-1:0]     value;
   logic [a2i_pkg::CONSUMED_BITS-1:0]  consumed;
   logic [a2i_pkg::ERROR_BITS-1:0]     error;

   // registers take a write in any cycle
   assign csr_ready = 1'b1;

   // phase machine and handshake
   a2i_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_start  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .sel        (sel),
      .cmd        (cmd)
   );

   // accumulator, counters, configuration and result register
   a2i_dpath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .chr          (req_tdata),
      .sel          (sel),
      .cmd          (cmd),
      .stat         (stat),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_value    (value),
      .rsp_consumed (consumed),
      .rsp_error    (error)
   );

   // pack the result fields, lowest field first
   assign rsp_tdata = {{FILL_BITS{1'b0}}, error, consumed, value};

endmodule

### verif/a2i_checker.sv
`timescale 1ns / 100ps
// a2i_checker: watches the req, rsp and csr channels of the ascii to integer
// parser, predicts every conversion result and compares it; depends on a2i_pkg
module a2i_checker
   import a2i_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [7:0]                 req_tdata,
   input  logic                       req_tuser,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [BASE_BITS-1:0]       csr_wdata,
   output int                         n_fail,
   output int                         waiting,
   output int                         n_results,
   output int                         n_range,
   output int                         n_bad_base
);

   typedef struct packed {
      logic [VALUE_BITS-1:0]    value;
      logic [CONSUMED_BITS-1:0] consumed;
      logic [ERROR_BITS-1:0]    error;
   } conv_result_type;

   // register copies
   logic [BASE_BITS-1:0]     cfg_base;
   logic                     cfg_signed;

   // conversion state
   phase_type                ph;
   logic [VALUE_BITS-1:0]    acc;
   logic                     neg;
   logic [CONSUMED_BITS-1:0] pos;
   logic                     started;
   logic [BASE_BITS-1:0]     wbase;

   logic                     produced;
   conv_result_type          produced_res;
   conv_result_type          pending_results[$];
   conv_result_type          got;
   conv_result_type          want;

   initial begin
      n_fail     = 0;
      n_results  = 0;
      n_range    = 0;
      n_bad_base = 0;
      waiting    = 0;
   end

   function automatic int char_digit(input logic [7:0] c);
      if (c >= CHR_0 && c <= CHR_9) return int'(c - CHR_0);
      if (c >= CHR_LA && c <= CHR_LZ) return int'(c - CHR_LA) + 10;
      if (c >= CHR_UA && c <= CHR_UZ) return int'(c - CHR_UA) + 10;
      return 99;
   endfunction

   function automatic void bump_position();
      if (pos != '1) pos++;
   endfunction

   function automatic void emit(input logic [VALUE_BITS-1:0] v,
                                input logic [CONSUMED_BITS-1:0] n,
                                input logic [ERROR_BITS-1:0] e);
      produced              = 1'b1;
      produced_res.value    = v;
      produced_res.consumed = n;
      produced_res.error    = e;
      ph                    = PH_IDLE;
   endfunction

   function automatic void take_digit(input logic [7:0] c);
      int d;
      logic [VALUE_BITS-1:0] lim;
      logic [VALUE_BITS-1:0] q;
      logic [VALUE_BITS-1:0] r;
      d = char_digit(c);
      if (wbase < BASE_MIN || wbase > BASE_MAX) wbase = BASE_DEC;
      if (d >= int'(wbase)) begin
         emit(neg ? -acc : acc, started ? pos : '0, ERR_OK);
         return;
      end
      if (cfg_signed) lim = neg ? SIGNED_MIN : SIGNED_MAX;
      else lim = UNSIGNED_MAX;
      q = lim / wbase;
      r = lim % wbase;
      if (acc > q || (acc == q && 64'(d) > r)) begin
         emit(cfg_signed ? (neg ? SIGNED_MIN : SIGNED_MAX) : UNSIGNED_MAX,
              started ? pos : '0, ERR_RANGE);
         return;
      end
      acc     = acc * wbase + 64'(d);
      bump_position();
      started = 1'b1;
      ph      = PH_DIGITS;
   endfunction

   function automatic void first_char(input logic [7:0] c);
      if ((wbase == BASE_AUTO || wbase == BASE_HEX) && c == CHR_0) begin
         acc     = '0;
         started = 1'b1;
         bump_position();
         ph      = PH_ZERO;
      end else begin
         if (wbase == BASE_AUTO) wbase = BASE_DEC;
         take_digit(c);
      end
   endfunction

   // one character of the stream; sets produced when a conversion ends
   function automatic void judge_char(input logic start, input logic [7:0] c);
      produced = 1'b0;
      if (start) begin
         acc     = '0;
         neg     = 1'b0;
         pos     = '0;
         started = 1'b0;
         wbase   = cfg_base;
         if (cfg_base == BASE_ONE || cfg_base > BASE_MAX) begin
            wbase = BASE_DEC;
            emit('0, '0, ERR_BASE);
            return;
         end
         ph = PH_WS;
      end
      case (ph)
         PH_WS: begin
            if (c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR)) begin
               bump_position();
            end else if (c == CHR_PLUS || c == CHR_MINUS) begin
               neg = (c == CHR_MINUS);
               bump_position();
               ph  = PH_SIGNED;
            end else begin
               first_char(c);
            end
         end
         PH_SIGNED: first_char(c);
         PH_ZERO: begin
            if (c == CHR_LX || c == CHR_UX) begin
               bump_position();
               ph = PH_ZERO_X;
            end else begin
               if (wbase == BASE_AUTO) wbase = BASE_OCT;
               take_digit(c);
            end
         end
         PH_ZERO_X: begin
            if (char_digit(c) < int'(BASE_HEX)) begin
               wbase = BASE_HEX;
               take_digit(c);
            end else begin
               emit('0, (pos != '0) ? pos - 1'b1 : '0, ERR_OK);
            end
         end
         PH_DIGITS: take_digit(c);
         default: ph = PH_IDLE;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [63:0] exp_v,
                                       input logic [63:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
         n_fail++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_base   = BASE_DEC;
         cfg_signed = 1'b1;
         ph         = PH_IDLE;
         acc        = '0;
         neg        = 1'b0;
         pos        = '0;
         started    = 1'b0;
         wbase      = BASE_DEC;
         pending_results.delete();
      end else begin
         // results first: one finishing in this cycle cannot leave before the next
         if (rsp_tvalid && rsp_tready) begin
            got = conv_result_type'({rsp_tdata[63:0], rsp_tdata[79:64], rsp_tdata[81:80]});
            n_results++;
            if (got.error == ERR_RANGE) n_range++;
            if (got.error == ERR_BASE) n_bad_base++;
            if (pending_results.size() == 0) begin
               $display("%0t: result with none expected, got value %0h consumed %0d error %0d",
                        $time, got.value, got.consumed, got.error);
               n_fail++;
            end else begin
               want = pending_results.pop_front();
               check_field("value", want.value, got.value);
               check_field("consumed", 64'(want.consumed), 64'(got.consumed));
               check_field("error", 64'(want.error), 64'(got.error));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE: cfg_base = csr_wdata;
               CSR_SIGNED: cfg_signed = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            judge_char(req_tuser, req_tdata);
            if (produced) pending_results.push_back(produced_res);
         end
      end
      waiting <= pending_results.size();
   end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for ascii_to_integer_parser; the a2i_checker
// instance predicts and compares; depends on a2i_pkg and the rtl top level
module tb;
   import a2i_pkg::*;

   // cycles with no transaction on any channel before the run is abandoned
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1150;
   localparam logic [7:0] CHR_SEMI = 8'h3B;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = '0;   // chr
   logic                      req_tuser  = 1'b0; // start_req
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // value [63:0], consumed [79:64], error [81:80], zero fill [87:82]
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [BASE_BITS-1:0]      csr_wdata  = '0;

   int n_fail;
   int waiting;
   int n_results;
   int n_range;
   int n_bad_base;

   int   n_items    = 0;
   int   n_modes    = 0;
   int   quiet_run  = 0;
   logic steady     = 1'b0;   // no idling on either side while set
   logic [BASE_BITS-1:0] cur_base = BASE_DEC;

   // settings walked first in the random part, the extremes among them
   logic [BASE_BITS-1:0] mode_base [13] = '{BASE_AUTO, BASE_AUTO, BASE_MIN, BASE_MIN,
                                            BASE_MAX, BASE_MAX, BASE_HEX, BASE_HEX,
                                            BASE_OCT, BASE_DEC, BASE_DEC, BASE_ONE,
                                            6'h3F};
   logic                 mode_sgn  [13] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                                            1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

   always #5 clock = ~clock;

   ascii_to_integer_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   a2i_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .n_fail     (n_fail),
      .waiting    (waiting),
      .n_results  (n_results),
      .n_range    (n_range),
      .n_bad_base (n_bad_base)
   );

   // receiver back pressure, ready low with a chance of about 13 in a hundred
   always @(posedge clock) begin
      rsp_tready <= !reset && (steady || $urandom_range(99) >= 13);
   end

   // watchdog: any accepted transaction restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_run <= 0;
      end else if (quiet_run >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("ascii_to_integer_parser test failed");
         $finish;
      end else begin
         quiet_run <= quiet_run + 1;
      end
   end

   // one character transaction; valid stays high into the next call when
   // no gap is drawn, so it is never dropped and raised in one step
   task automatic send_char(input logic start, input logic [7:0] c);
      while (!steady && $urandom_range(99) < 13) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= start;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      n_items++;
   endtask

   task automatic send_text(input string s, input logic lead_start);
      for (int i = 0; i < s.len(); i++) send_char(lead_start && i == 0, s[i]);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [BASE_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // end any open conversion and wait until every result is out
   task automatic drain();
      send_char(1'b0, CHR_SEMI);   // ends a conversion in any phase, ignored when idle
      req_tvalid <= 1'b0;
      repeat (4) @(posedge clock);
      while (waiting != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_mode(input logic [BASE_BITS-1:0] b, input logic sg);
      drain();
      csr_write(CSR_BASE, b);
      csr_write(CSR_SIGNED, BASE_BITS'(sg));
      csr_valid <= 1'b0;
      cur_base = b;
      n_modes++;
   endtask

   function automatic logic [7:0] digit_char(input int d);
      if (d < 10) return 8'(CHR_0 + d);
      return 8'(($urandom_range(1) ? CHR_LA : CHR_UA) + d - 10);
   endfunction

   task automatic append_value(ref logic [7:0] s[$], input logic [63:0] v, input int b);
      logic [7:0] rev[$];
      do begin
         rev.push_front(digit_char(int'(v % b)));
         v = v / b;
      end while (v != 0);
      foreach (rev[i]) s.push_back(rev[i]);
   endtask

   // a number text for the current base: whitespace, sign, prefix, digits
   // and a terminator, with now and then a damaged byte or no terminator
   task automatic make_conversion(ref logic [7:0] s[$]);
      int eff;
      int w;
      logic [63:0] v;
      string ends;
      ends = ";, \n.";
      s.delete();
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            w = $urandom_range(9, 14);
            s.push_back(w == 14 ? CHR_SPACE : 8'(w));
         end
      end
      case ($urandom_range(3))
         0: s.push_back(CHR_MINUS);
         1: s.push_back(CHR_PLUS);
         default: ;
      endcase
      eff = (cur_base >= BASE_MIN && cur_base <= BASE_MAX) ? int'(cur_base) : 10;
      if ((cur_base == BASE_AUTO || cur_base == BASE_HEX) && $urandom_range(2) == 0) begin
         s.push_back(CHR_0);
         s.push_back($urandom_range(1) ? CHR_LX : CHR_UX);
         eff = 16;
      end else if (cur_base == BASE_AUTO && $urandom_range(3) == 0) begin
         s.push_back(CHR_0);
         eff = 8;
      end
      case ($urandom_range(9))
         0, 1, 2: repeat ($urandom_range(1, 12)) s.push_back(digit_char($urandom_range(eff - 1)));
         3: repeat ($urandom_range(1, 70)) s.push_back(digit_char($urandom_range(eff - 1)));
         4, 5, 6: begin
            // around the signed and unsigned limits, sometimes one digit past them
            case ($urandom_range(2))
               0: v = SIGNED_MAX;
               1: v = SIGNED_MIN;
               default: v = UNSIGNED_MAX;
            endcase
            v = v + $urandom_range(4);
            v = v - 2;
            append_value(s, v, eff);
            if ($urandom_range(3) == 0) s.push_back(digit_char($urandom_range(eff - 1)));
         end
         7: append_value(s, {$urandom, $urandom}, eff);
         8: ;
         default: begin
            repeat ($urandom_range(1, 5)) s.push_back(CHR_0);
            append_value(s, 64'($urandom_range(999)), eff);
         end
      endcase
      if ($urandom_range(9) != 0) begin
         if ($urandom_range(3) == 0) s.push_back(8'($urandom_range(255)));
         else s.push_back(ends[$urandom_range(ends.len() - 1)]);
      end
      if ($urandom_range(7) == 0 && s.size() > 0) begin
         s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255));
      end
   endtask

   initial begin
      logic [7:0] text[$];
      logic [BASE_BITS-1:0] b;
      logic sg;
      int k;
      int target;
      int phase_end;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: decimal signed, the reset setting written explicitly
      set_mode(BASE_DEC, 1'b1);
      send_text("\011\012\013\014\015 42;", 1'b1);   // every whitespace byte
      send_text("+7;", 1'b1);
      send_text(" -;", 1'b1);                          // sign with no digits
      send_text("9223372036854775807;", 1'b1);
      send_text("9223372036854775808;", 1'b1);         // signed overflow
      send_text("-9223372036854775808;", 1'b1);
      send_text("-9223372036854775809;", 1'b1);        // negative overflow
      send_text("123", 1'b1);                          // dropped by the restart
      send_text("45 ", 1'b1);
      send_text("99", 1'b0);                           // no start while idle
      send_char(1'b1, 8'hFF);
      send_char(1'b1, 8'h00);
      send_text("Zz", 1'b1);
      // a long run of leading zeros
      send_char(1'b1, CHR_0);
      repeat (40) send_char(1'b0, CHR_0);
      send_text("7;", 1'b0);

      // auto base detection and the dangling hex prefix
      set_mode(BASE_AUTO, 1'b1);
      send_text("0x1A;", 1'b1);
      send_text("0X;", 1'b1);
      send_text("017;", 1'b1);
      send_text("089", 1'b1);
      send_text("-0x8000000000000001;", 1'b1);

      // unsigned hex: limit, overflow, minus wraps
      set_mode(BASE_HEX, 1'b0);
      send_text("0xFFFFFFFFFFFFFFFF;", 1'b1);
      send_text("0x10000000000000000;", 1'b1);
      send_text("-1;", 1'b1);
      send_text("0xg;", 1'b1);

      set_mode(BASE_MAX, 1'b1);
      send_text("zZ;", 1'b1);
      set_mode(BASE_MIN, 1'b0);
      send_text("-101;", 1'b1);

      // invalid bases answer on the start character and then go idle
      set_mode(BASE_ONE, 1'b1);
      send_text("5;", 1'b1);
      set_mode(BASE_MAX + 1'b1, 1'b0);
      send_text("5;", 1'b1);

      // random: fixed extreme settings first, then random ones
      k = 0;
      target = n_items + RANDOM_ITEMS;
      while (n_items < target) begin
         if (k < 13) begin
            b  = mode_base[k];
            sg = mode_sgn[k];
         end else begin
            b  = ($urandom_range(9) == 0) ? BASE_BITS'($urandom_range(63))
                                          : BASE_BITS'($urandom_range(2, 36));
            sg = $urandom_range(1);
         end
         set_mode(b, sg);
         steady = (k == 5);   // one whole setting with no idling anywhere
         phase_end = n_items + ((b == BASE_ONE || b > BASE_MAX) ? 15 : 100);
         while (n_items < phase_end) begin
            if ($urandom_range(9) == 0) begin
               // stray byte with a random start mark
               send_char($urandom_range(1), 8'($urandom_range(255)));
            end else begin
               make_conversion(text);
               foreach (text[i]) send_char(i == 0, text[i]);
            end
         end
         k++;
      end
      steady = 1'b0;
      drain();

      $display("run covered %0d characters over %0d register settings", n_items, n_modes);
      $display("%0d results checked, %0d out of range, %0d invalid base",
               n_results, n_range, n_bad_base);
      if (n_fail == 0) begin
         $display("ascii_to_integer_parser test passed");
      end else begin
         $display("ascii_to_integer_parser test failed");
      end
      $finish;
   end

endmodule

### ascii_to_integer_parser.f
rtl/a2i_pkg.sv
rtl/a2i_ctrl.sv
rtl/a2i_dpath.sv
rtl/ascii_to_integer_parser.sv
verif/a2i_checker.sv
verif/tb.sv
